FILE: design/csvt_pkg.sv
package csvt_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    typedef enum logic [2:0] {
        MODE_UNQUOTED = 3'd0,
        MODE_QUOTED   = 3'd1,
        MODE_PENDING  = 3'd2,
        MODE_CLOSED   = 3'd3,
        MODE_ERROR    = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        KIND_CONTENT = 2'd0,
        KIND_FIELD   = 2'd1,
        KIND_RECORD  = 2'd2,
        KIND_ERROR   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ERR_AFTER_CLOSE = 2'd0,
        ERR_BARE_QUOTE  = 2'd1,
        ERR_OPEN_QUOTE  = 2'd2
    } t_err;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic        blank;
        t_err        err;
    } t_event;

    // All events caused by one input byte: one or two.
    typedef struct packed {
        logic   two;
        t_event first;
        t_event second;
    } t_bundle;

endpackage

FILE: design/csvt_front.sv
module csvt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [7:0]        i_cfg_wr_data,
    input  logic              i_push,
    input  logic [7:0]        i_in_byte,
    input  logic              i_end_of_input,
    output logic              o_full,
    input  logic              i_q_full,
    output logic              o_q_push,
    output csvt_pkg::t_bundle o_q_data
);
    import csvt_pkg::*;

    logic [7:0] r_sep;
    t_mode      r_mode, n_mode;
    logic       r_skip, n_skip;
    logic       r_begun, n_begun;
    logic       r_has_sep, n_has_sep;
    logic       r_all_blank, n_all_blank;

    logic       acc;
    logic       run;
    logic       do_close;
    logic       do_plain;
    logic       has_a, has_b;
    t_event     ev_a, ev_b;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic t_event make_event(input t_kind k, input logic [7:0] d,
                                          input logic b, input t_err e);
        t_event ev;
        ev.kind  = k;
        ev.data  = d;
        ev.blank = b;
        ev.err   = e;
        return ev;
    endfunction

    assign acc = i_push && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep <= CH_COMMA;
        end else if (i_cfg_wr_en && i_cfg_wr_data != CH_NUL && i_cfg_wr_data != CH_CR &&
                     i_cfg_wr_data != CH_LF && i_cfg_wr_data != CH_QUOTE) begin
            r_sep <= i_cfg_wr_data;
        end
    end

    // Next state and the events of the byte taken in this cycle.
    always_comb begin
        n_mode      = r_mode;
        n_skip      = r_skip;
        n_begun     = r_begun;
        n_has_sep   = r_has_sep;
        n_all_blank = r_all_blank;
        run         = 1'b1;
        do_close    = 1'b0;
        do_plain    = 1'b0;
        has_a       = 1'b0;
        has_b       = 1'b0;
        ev_a        = make_event(KIND_CONTENT, CH_NUL, 1'b0, ERR_AFTER_CLOSE);
        ev_b        = make_event(KIND_CONTENT, CH_NUL, 1'b0, ERR_AFTER_CLOSE);
        if (acc) begin
            if (n_skip) begin
                n_skip = 1'b0;
                if (i_in_byte == CH_LF) begin
                    run = 1'b0;
                end
            end
            if (run) begin
                case (n_mode)
                    MODE_ERROR: begin
                    end
                    MODE_QUOTED: begin
                        if (i_in_byte == CH_QUOTE) begin
                            n_mode = MODE_PENDING;
                        end else if (i_in_byte == CH_CR) begin
                            n_skip = 1'b1;
                            has_a  = 1'b1;
                            ev_a   = make_event(KIND_CONTENT, CH_LF, 1'b0, ERR_AFTER_CLOSE);
                        end else begin
                            if (!is_space(i_in_byte)) begin
                                n_all_blank = 1'b0;
                            end
                            has_a = 1'b1;
                            ev_a  = make_event(KIND_CONTENT, i_in_byte, 1'b0, ERR_AFTER_CLOSE);
                        end
                    end
                    MODE_PENDING: begin
                        if (i_in_byte == CH_QUOTE) begin
                            // doubled quote: emit one literal quote
                            n_all_blank = 1'b0;
                            has_a       = 1'b1;
                            ev_a        = make_event(KIND_CONTENT, CH_QUOTE, 1'b0,
                                                     ERR_AFTER_CLOSE);
                            n_mode      = MODE_QUOTED;
                        end else begin
                            n_mode   = MODE_CLOSED;
                            do_close = 1'b1;
                        end
                    end
                    MODE_CLOSED: begin
                        do_close = 1'b1;
                    end
                    MODE_UNQUOTED: begin
                        do_plain = 1'b1;
                    end
                    default: begin
                    end
                endcase

                if (do_close || do_plain) begin
                    if (i_in_byte == r_sep) begin
                        has_a     = 1'b1;
                        ev_a      = make_event(KIND_FIELD, CH_NUL, 1'b0, ERR_AFTER_CLOSE);
                        n_has_sep = 1'b1;
                        n_begun   = 1'b0;
                        n_mode    = MODE_UNQUOTED;
                    end else if (i_in_byte == CH_CR || i_in_byte == CH_LF) begin
                        if (i_in_byte == CH_CR) begin
                            n_skip = 1'b1;
                        end
                        has_a       = 1'b1;
                        ev_a        = make_event(KIND_RECORD, CH_NUL,
                                                 !n_has_sep && n_all_blank, ERR_AFTER_CLOSE);
                        n_has_sep   = 1'b0;
                        n_all_blank = 1'b1;
                        n_begun     = 1'b0;
                        n_mode      = MODE_UNQUOTED;
                    end else if (do_close) begin
                        has_a  = 1'b1;
                        ev_a   = make_event(KIND_ERROR, CH_NUL, 1'b0, ERR_AFTER_CLOSE);
                        n_mode = MODE_ERROR;
                    end else if (i_in_byte == CH_QUOTE) begin
                        if (n_begun) begin
                            has_a  = 1'b1;
                            ev_a   = make_event(KIND_ERROR, CH_NUL, 1'b0, ERR_BARE_QUOTE);
                            n_mode = MODE_ERROR;
                        end else begin
                            n_mode  = MODE_QUOTED;
                            n_begun = 1'b1;
                        end
                    end else begin
                        n_begun = 1'b1;
                        if (!is_space(i_in_byte)) begin
                            n_all_blank = 1'b0;
                        end
                        has_a = 1'b1;
                        ev_a  = make_event(KIND_CONTENT, i_in_byte, 1'b0, ERR_AFTER_CLOSE);
                    end
                end
            end

            // close out the text, then restart parsing
            if (i_end_of_input) begin
                if (n_mode == MODE_QUOTED) begin
                    has_b = 1'b1;
                    ev_b  = make_event(KIND_ERROR, CH_NUL, 1'b0, ERR_OPEN_QUOTE);
                end else if (n_mode != MODE_ERROR &&
                             (n_begun || n_mode == MODE_PENDING ||
                              n_mode == MODE_CLOSED || n_has_sep)) begin
                    has_b = 1'b1;
                    ev_b  = make_event(KIND_RECORD, CH_NUL, !n_has_sep && n_all_blank,
                                       ERR_AFTER_CLOSE);
                end
                n_mode      = MODE_UNQUOTED;
                n_skip      = 1'b0;
                n_begun     = 1'b0;
                n_has_sep   = 1'b0;
                n_all_blank = 1'b1;
            end
        end
    end

    always_comb begin
        o_full          = i_q_full;
        o_q_push        = acc && (has_a || has_b);
        o_q_data.two    = has_a && has_b;
        o_q_data.first  = has_a ? ev_a : ev_b;
        o_q_data.second = ev_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_UNQUOTED;
            r_skip      <= 1'b0;
            r_begun     <= 1'b0;
            r_has_sep   <= 1'b0;
            r_all_blank <= 1'b1;
        end else begin
            r_mode      <= n_mode;
            r_skip      <= n_skip;
            r_begun     <= n_begun;
            r_has_sep   <= n_has_sep;
            r_all_blank <= n_all_blank;
        end
    end

    a_error_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && r_mode == MODE_ERROR && !i_end_of_input) |-> !o_q_push)
        else $error("event pushed while parser is in error");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_end_of_input) |=>
            (r_mode == MODE_UNQUOTED && !r_skip && !r_begun && !r_has_sep && r_all_blank))
        else $error("parse state not cleared after end of input");

    a_sep_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sep != CH_NUL && r_sep != CH_CR && r_sep != CH_LF && r_sep != CH_QUOTE)
        else $error("illegal separator held");

endmodule

FILE: design/csvt_queue.sv
module csvt_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  csvt_pkg::t_bundle i_data,
    output logic              o_full,
    input  logic              i_pop,
    output csvt_pkg::t_bundle o_data,
    output logic              o_empty
);
    import csvt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_bundle            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               wr, rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({wr, rd})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

FILE: design/csvt_back.sv
module csvt_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  csvt_pkg::t_bundle i_q_data,
    input  logic              i_q_empty,
    output logic              o_q_pop,
    output logic              o_empty,
    input  logic              i_pop,
    output logic [1:0]        o_event_kind,
    output logic [7:0]        o_content_byte,
    output logic              o_blank_record,
    output logic [1:0]        o_error_code,
    output logic              o_last_of_run
);
    import csvt_pkg::*;

    t_bundle r_bnd, n_bnd;
    logic    r_valid, n_valid;
    logic    r_sel, n_sel;
    logic    last;
    logic    take;
    logic    load;
    t_event  ev;

    assign last    = !r_bnd.two || r_sel;
    assign take    = r_valid && i_pop;
    assign load    = (!r_valid || (take && last)) && !i_q_empty;
    assign o_q_pop = load;

    always_comb begin
        n_valid = r_valid;
        n_sel   = r_sel;
        n_bnd   = r_bnd;
        if (!r_valid || (take && last)) begin
            n_valid = !i_q_empty;
            n_sel   = 1'b0;
        end else if (take) begin
            n_sel = 1'b1;
        end
        if (load) begin
            n_bnd = i_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sel   <= n_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bnd <= n_bnd;
    end

    always_comb begin
        ev             = r_sel ? r_bnd.second : r_bnd.first;
        o_empty        = !r_valid;
        o_event_kind   = ev.kind;
        o_content_byte = ev.data;
        o_blank_record = ev.blank;
        o_error_code   = ev.err;
        o_last_of_run  = last;
    end

    a_sel_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_sel) |-> r_bnd.two)
        else $error("second event selected from a single-event run");

    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !last) |=> (r_valid && r_sel))
        else $error("second event of run lost");

endmodule

FILE: design/csv_byte_tokenizer.sv
// Streaming CSV tokenizer. One text byte is taken per cycle whenever full is low; each byte
// gives zero, one or two token events (content byte, field end, record end, error), and the
// last event of a byte carries o_last_of_run. Bytes are parsed in the front stage and their
// events travel as one entry through a QUEUE_DEPTH-entry queue to the registered output stage,
// which hands out one event per cycle while pop is high and it holds an event; the input rate
// is therefore one byte per cycle while results are popped every cycle and bytes give at most
// one event, and the output port sets the pace for bytes that give two events. The separator
// register may be written only while idle.
module csv_byte_tokenizer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_event_kind,
    output logic [7:0] o_content_byte,
    output logic       o_blank_record,
    output logic [1:0] o_error_code,
    output logic       o_last_of_run
);
    import csvt_pkg::*;

    t_bundle q_in_data;
    t_bundle q_out_data;
    logic    q_push;
    logic    q_full;
    logic    q_pop;
    logic    q_empty;

    csvt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_push         (push),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .o_full         (full),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_data       (q_in_data)
    );

    csvt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out_data),
        .o_empty (q_empty)
    );

    csvt_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_data       (q_out_data),
        .i_q_empty      (q_empty),
        .o_q_pop        (q_pop),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_event_kind   (o_event_kind),
        .o_content_byte (o_content_byte),
        .o_blank_record (o_blank_record),
        .o_error_code   (o_error_code),
        .o_last_of_run  (o_last_of_run)
    );

endmodule
